### hw/rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and byte codes of the text stream cleaner.
// ----------------------------------------------------------------------------
package tsc_pkg;

    // Byte codes
    localparam logic [7:0] LEAD_C2   = 8'hC2;
    localparam logic [7:0] LEAD_E2   = 8'hE2;
    localparam logic [7:0] NBSP      = 8'hA0;
    localparam logic [7:0] CONT_80   = 8'h80;
    localparam logic [7:0] ZW_SPACE  = 8'h8B;
    localparam logic [7:0] ZW_NJOIN  = 8'h8C;
    localparam logic [7:0] ZW_JOIN   = 8'h8D;
    localparam logic [7:0] SOFT_HYPH = 8'hAD;
    localparam logic [7:0] SPACE     = 8'h20;
    localparam logic [7:0] DEL       = 8'h7F;
    localparam logic [7:0] TAB       = 8'h09;
    localparam logic [7:0] LF        = 8'h0A;
    localparam logic [7:0] CR        = 8'h0D;
    localparam logic [7:0] CTRL_MAX  = 8'h1F;

    // Prefix state codes
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_LEAD = 2'd1;
    localparam logic [1:0] PEND_E280 = 2'd2;

    // Results one request hands to the back end at most
    localparam int MAX_OUT = 4;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    localparam int IDX_W   = $clog2(MAX_OUT);

    typedef struct packed {
        logic       res_empty;
        logic       res_last;
        logic [7:0] res_data;
    } result_t;

    typedef struct packed {
        result_t [MAX_OUT-1:0] res;
        logic [CNT_W-1:0]      cnt;
    } bundle_t;

endpackage

### hw/rtl/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Classifies each input byte, tracks prefix and spacing state, and writes
// the results of one request as a bundle into the queue.
// ----------------------------------------------------------------------------
module tsc_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             in_empty,
    input  logic             q_full,
    output logic             q_push,
    output tsc_pkg::bundle_t q_data
);

    localparam int SLOTS  = tsc_pkg::MAX_OUT + 2;
    localparam int SLOT_W = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [7:0]                     lead;
        logic [1:0]                     pend;
        logic [7:0]                     held;
        logic                           held_v;
        logic                           owed;
        logic                           started;
        tsc_pkg::result_t [SLOTS-1:0]   slot;
        logic [SLOT_W-1:0]              n;
    } work_t;

    logic [7:0]       lead_reg, lead_next;
    logic [1:0]       pend_reg, pend_next;
    logic [7:0]       held_reg, held_next;
    logic             held_v_reg, held_v_next;
    logic             owed_reg, owed_next;
    logic             started_reg, started_next;
    logic             ovf_valid_reg, ovf_valid_next;
    tsc_pkg::result_t ovf_res_reg, ovf_res_next;
    logic             accept;
    work_t            w;

    function automatic work_t f_emit(work_t s, logic [7:0] d, logic l, logic e);
        if (s.n < SLOT_W'(SLOTS))
        begin
            s.slot[s.n[SLOT_W-1:0]].res_data  = d;
            s.slot[s.n[SLOT_W-1:0]].res_last  = l;
            s.slot[s.n[SLOT_W-1:0]].res_empty = e;
            s.n = s.n + SLOT_W'(1);
        end
        return s;
    endfunction

    function automatic work_t f_hold(work_t s, logic [7:0] c);
        if (s.held_v)
        begin
            s = f_emit(s, s.held, 1'b0, 1'b0);
        end
        s.held   = c;
        s.held_v = 1'b1;
        return s;
    endfunction

    // Collapse runs of spaces; a space is owed only once text has started.
    function automatic work_t f_collapse(work_t s, logic [7:0] c);
        if (c == tsc_pkg::SPACE)
        begin
            if (s.started)
            begin
                s.owed = 1'b1;
            end
        end
        else
        begin
            if (s.owed)
            begin
                s      = f_hold(s, tsc_pkg::SPACE);
                s.owed = 1'b0;
            end
            s         = f_hold(s, c);
            s.started = 1'b1;
        end
        return s;
    endfunction

    function automatic work_t f_fresh(work_t s, logic [7:0] c);
        case (c) inside
            tsc_pkg::LEAD_C2, tsc_pkg::LEAD_E2:
            begin
                s.lead = c;
                s.pend = tsc_pkg::PEND_LEAD;
            end
            tsc_pkg::NBSP:
            begin
                s = f_collapse(s, tsc_pkg::SPACE);
            end
            [8'h00:tsc_pkg::CTRL_MAX], tsc_pkg::DEL:
            begin
                case (c) inside
                    tsc_pkg::TAB, tsc_pkg::LF, tsc_pkg::CR:
                    begin
                        s = f_collapse(s, tsc_pkg::SPACE);
                    end
                    default:
                    begin
                        // drop
                    end
                endcase
            end
            default:
            begin
                s = f_collapse(s, c);
            end
        endcase
        return s;
    endfunction

    function automatic work_t f_take(work_t s, logic [7:0] b);
        if (s.pend == tsc_pkg::PEND_NONE)
        begin
            s = f_fresh(s, b);
        end
        else if (s.lead == tsc_pkg::LEAD_C2)
        begin
            s.pend = tsc_pkg::PEND_NONE;
            s.lead = 8'h00;
            if (b == tsc_pkg::NBSP)
            begin
                s = f_collapse(s, tsc_pkg::SPACE);
            end
            else if (b != tsc_pkg::SOFT_HYPH)
            begin
                s = f_collapse(s, tsc_pkg::LEAD_C2);
                s = f_fresh(s, b);
            end
        end
        else if (s.pend == tsc_pkg::PEND_LEAD)
        begin
            if (b == tsc_pkg::CONT_80)
            begin
                s.pend = tsc_pkg::PEND_E280;
            end
            else
            begin
                s.pend = tsc_pkg::PEND_NONE;
                s.lead = 8'h00;
                s      = f_collapse(s, tsc_pkg::LEAD_E2);
                s      = f_fresh(s, b);
            end
        end
        else
        begin
            s.pend = tsc_pkg::PEND_NONE;
            s.lead = 8'h00;
            if (b != tsc_pkg::ZW_SPACE && b != tsc_pkg::ZW_NJOIN && b != tsc_pkg::ZW_JOIN)
            begin
                s = f_collapse(s, tsc_pkg::LEAD_E2);
                s = f_fresh(s, tsc_pkg::CONT_80);
                s = f_fresh(s, b);
            end
        end
        return s;
    endfunction

    // Flush open prefix, send held byte or empty marker as last, clear string.
    function automatic work_t f_end(work_t s);
        if (s.pend != tsc_pkg::PEND_NONE)
        begin
            s = f_collapse(s, (s.lead == tsc_pkg::LEAD_C2) ? tsc_pkg::LEAD_C2
                                                           : tsc_pkg::LEAD_E2);
            if (s.pend == tsc_pkg::PEND_E280 && s.lead != tsc_pkg::LEAD_C2)
            begin
                s = f_collapse(s, tsc_pkg::CONT_80);
            end
        end
        if (s.held_v)
        begin
            s = f_emit(s, s.held, 1'b1, 1'b0);
        end
        else
        begin
            s = f_emit(s, 8'h00, 1'b1, 1'b1);
        end
        s.lead    = 8'h00;
        s.pend    = tsc_pkg::PEND_NONE;
        s.held    = 8'h00;
        s.held_v  = 1'b0;
        s.owed    = 1'b0;
        s.started = 1'b0;
        return s;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        w         = '0;
        w.lead    = lead_reg;
        w.pend    = pend_reg;
        w.held    = held_reg;
        w.held_v  = held_v_reg;
        w.owed    = owed_reg;
        w.started = started_reg;
        // A result left over from the previous request goes first.
        if (ovf_valid_reg)
        begin
            w = f_emit(w, ovf_res_reg.res_data, ovf_res_reg.res_last,
                       ovf_res_reg.res_empty);
        end
        if (in_empty)
        begin
            w = f_end(w);
        end
        else
        begin
            w = f_take(w, in_byte);
            if (in_last)
            begin
                w = f_end(w);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < tsc_pkg::MAX_OUT; k++)
        begin
            q_data.res[k] = w.slot[k];
        end
        q_data.cnt = (w.n > SLOT_W'(tsc_pkg::MAX_OUT)) ? tsc_pkg::CNT_W'(tsc_pkg::MAX_OUT)
                                                       : tsc_pkg::CNT_W'(w.n);
        q_push = accept && (w.n != '0);
    end

    always_comb
    begin
        lead_next      = lead_reg;
        pend_next      = pend_reg;
        held_next      = held_reg;
        held_v_next    = held_v_reg;
        owed_next      = owed_reg;
        started_next   = started_reg;
        ovf_valid_next = ovf_valid_reg;
        ovf_res_next   = ovf_res_reg;
        if (accept)
        begin
            lead_next      = w.lead;
            pend_next      = w.pend;
            held_next      = w.held;
            held_v_next    = w.held_v;
            owed_next      = w.owed;
            started_next   = w.started;
            // Keep the fifth result until the next request arrives.
            ovf_valid_next = (w.n > SLOT_W'(tsc_pkg::MAX_OUT));
            ovf_res_next   = w.slot[tsc_pkg::MAX_OUT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg      <= 8'h00;
            pend_reg      <= tsc_pkg::PEND_NONE;
            held_reg      <= 8'h00;
            held_v_reg    <= 1'b0;
            owed_reg      <= 1'b0;
            started_reg   <= 1'b0;
            ovf_valid_reg <= 1'b0;
        end
        else
        begin
            lead_reg      <= lead_next;
            pend_reg      <= pend_next;
            held_reg      <= held_next;
            held_v_reg    <= held_v_next;
            owed_reg      <= owed_next;
            started_reg   <= started_next;
            ovf_valid_reg <= ovf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_res_reg <= ovf_res_next;
    end

endmodule

### hw/rtl/tsc_queue.sv
// ----------------------------------------------------------------------------
// tsc_queue
// Small FIFO of result bundles between front and back end.
// ----------------------------------------------------------------------------
module tsc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tsc_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output tsc_pkg::bundle_t head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tsc_pkg::bundle_t        mem_reg [DEPTH];
    logic [AW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/tsc_back.sv
// ----------------------------------------------------------------------------
// tsc_back
// Serializes each queued bundle into single results through an output
// register.
// ----------------------------------------------------------------------------
module tsc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  tsc_pkg::bundle_t head_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output tsc_pkg::result_t out_res
);

    logic [tsc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    tsc_pkg::result_t          out_res_reg, out_res_next;
    logic                      advance;
    logic                      take;

    assign advance = !out_valid_reg || out_ready;
    assign take    = advance && head_valid;
    // Release the bundle with its final result.
    assign pop     = take &&
                     (tsc_pkg::CNT_W'(idx_reg) + tsc_pkg::CNT_W'(1) >= head_data.cnt);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance)
        begin
            out_valid_next = head_valid;
        end
        if (take)
        begin
            out_res_next = head_data.res[idx_reg];
            idx_next     = pop ? '0 : idx_reg + tsc_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

### hw/rtl/text_stream_cleaner_core.sv
// ----------------------------------------------------------------------------
// text_stream_cleaner_core
// Cleans a byte stream of strings: maps non-breaking and white-space bytes
// to spaces, drops zero-width and control bytes, collapses and trims spaces.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata        tlast             tuser
//  s_axis    in   [7:0] byte   last byte         empty string
//  m_axis    out  [7:0] byte   last result       empty result (tdata 0)
//
//  One byte is taken per cycle while the bundle queue has room; a byte that
//  yields k results holds the back end until all k are sent, one result per
//  cycle at the output register while the output is ready.
//  The queue of QUEUE_DEPTH bundles absorbs flushes at string ends.
//  Reset clears all string state, the queue and the output valid.
//  An output stall holds the output register; input ready drops only when
//  the queue is full.
// ----------------------------------------------------------------------------
module text_stream_cleaner_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    input  logic       s_axis_tuser,   // [0] in_empty
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // out_last
    output logic       m_axis_tuser    // [0] out_empty
);

    logic             q_push;
    tsc_pkg::bundle_t q_wdata;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    tsc_pkg::bundle_t q_head;
    tsc_pkg::result_t out_res;

    tsc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .in_empty (s_axis_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    tsc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    tsc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (out_res)
    );

    assign m_axis_tdata = out_res.res_data;
    assign m_axis_tlast = out_res.res_last;
    assign m_axis_tuser = out_res.res_empty;

endmodule

### hw/rtl/tsc_checker.sv
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the text stream cleaner, bound to the top level.
// ----------------------------------------------------------------------------
module tsc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // An empty marker closes its string and carries a zero byte.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("empty marker without last or with nonzero data");

    // Trailing spaces are trimmed.
    a_no_trailing_space: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata != 8'h20)
        else $error("string ends in a space");

    // Control bytes, DEL and a bare no-break byte never pass.
    a_no_control: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata >= 8'h20) && (m_axis_tdata != 8'h7F) && (m_axis_tdata != 8'hA0))
        else $error("control or no-break byte on output");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind text_stream_cleaner_core tsc_checker u_tsc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
